/* rtl/core/mdtr_pkg.sv */
// ---------------------------------------------------------------------------
// mdtr_pkg: shared types and constants of the decode time restamper
// Parse phases, box type codes, the queue entry layout and the queue size.
// ---------------------------------------------------------------------------
package mdtr_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_VERFLAGS,
      PH_TIME,
      PH_DONE
   } parse_phase_type;

   localparam logic [31:0] FOURCC_TFDT = 32'h74666474;
   localparam logic [31:0] FOURCC_TRAF = 32'h74726166;
   localparam logic [31:0] FOURCC_MOOV = 32'h6d6f6f76;
   localparam logic [31:0] FOURCC_TRAK = 32'h7472616b;
   localparam logic [31:0] FOURCC_MINF = 32'h6d696e66;
   localparam logic [31:0] FOURCC_DINF = 32'h64696e66;
   localparam logic [31:0] FOURCC_STBL = 32'h7374626c;
   localparam logic [31:0] FOURCC_MVEX = 32'h6d766578;
   localparam logic [31:0] FOURCC_MOOF = 32'h6d6f6f66;
   localparam logic [31:0] FOURCC_MDIA = 32'h6d646961;

   localparam logic [31:0] MIN_BOX_SIZE = 32'd8;
   localparam logic [7:0]  TFDT_VERSION_LONG = 8'd1;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic        REG_RESTAMP_DELTA = 1'b0;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  count;
      logic        last;
      logic        found;
      logic [63:0] stamp;
      logic        malformed;
   } mdtr_entry_type;

   function automatic logic is_container(input logic [31:0] fourcc);
      is_container = (fourcc == FOURCC_TRAF) || (fourcc == FOURCC_MOOV) ||
                     (fourcc == FOURCC_TRAK) || (fourcc == FOURCC_MINF) ||
                     (fourcc == FOURCC_DINF) || (fourcc == FOURCC_STBL) ||
                     (fourcc == FOURCC_MVEX) || (fourcc == FOURCC_MOOF) ||
                     (fourcc == FOURCC_MDIA);
   endfunction

endpackage

/* rtl/core/mdtr_req_if.sv */
// ---------------------------------------------------------------------------
// mdtr_req_if: segment byte channel
// Valid/ready channel that carries one segment byte and its end mark.
// ---------------------------------------------------------------------------
interface mdtr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       segment_last;

   modport source (output valid, output in_byte, output segment_last, input ready);
   modport sink (input valid, input in_byte, input segment_last, output ready);
endinterface

/* rtl/core/mdtr_rsp_if.sv */
// ---------------------------------------------------------------------------
// mdtr_rsp_if: restamped byte channel
// Valid/ready channel that carries one output byte and the segment summary.
// ---------------------------------------------------------------------------
interface mdtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        segment_end;
   logic        time_found;
   logic [63:0] new_decode_time;
   logic        malformed;

   modport source (output valid, output out_byte, output segment_end, output time_found,
                   output new_decode_time, output malformed, input ready);
   modport sink (input valid, input out_byte, input segment_end, input time_found,
                 input new_decode_time, input malformed, output ready);
endinterface

/* rtl/core/mdtr_queue.sv */
// ---------------------------------------------------------------------------
// mdtr_queue: entry queue between parser and emitter
// Small circular buffer of byte groups produced by the parser.
// ---------------------------------------------------------------------------
module mdtr_queue
   import mdtr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mdtr_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output mdtr_entry_type head_entry
);

   mdtr_entry_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/mdtr_front.sv */
// ---------------------------------------------------------------------------
// mdtr_front: box parser and time field rewriter
// Tracks box headers and open containers, finds the first tfdt time field,
// adds the delta and pushes byte groups into the queue.
// ---------------------------------------------------------------------------
module mdtr_front
   import mdtr_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 8
)(
   input  logic           clock,
   input  logic           reset,
   mdtr_req_if.sink       req_chan,
   input  logic [63:0]    restamp_delta,
   input  logic           queue_full,
   output logic           push,
   output mdtr_entry_type push_entry
);

   localparam int unsigned NEST_W = $clog2(MAX_DEPTH + 1);
   localparam int unsigned IDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   parse_phase_type    phase_ff, phase_in;
   logic [31:0]        stack_ff [MAX_DEPTH];
   logic [31:0]        stack_in [MAX_DEPTH];
   logic [NEST_W-1:0]  nest_ff, nest_in;
   logic [63:0]        shift_ff, shift_in;
   logic [3:0]         count_ff, count_in;
   logic               wide_ff, wide_in;
   logic [63:0]        held_ff, held_in;
   logic               found_ff, found_in;
   logic [63:0]        found_time_ff, found_time_in;
   logic               error_ff, error_in;

   logic               accept;
   logic [63:0]        time_shift;
   logic [63:0]        time_sum;
   logic [63:0]        new_time;
   logic [3:0]         need;
   logic               time_done;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   assign time_shift = {held_ff[55:0], req_chan.in_byte};
   assign time_sum   = time_shift + restamp_delta;
   assign new_time   = wide_ff ? time_sum : {32'd0, time_sum[31:0]};
   assign need       = wide_ff ? 4'd8 : 4'd4;
   assign time_done  = (count_ff + 4'd1 == need);

   always_comb begin
      logic [63:0] header;
      logic [31:0] box_size;
      logic [31:0] box_type;
      logic [31:0] body;
      logic [63:0] skip_left;
      logic        stop;
      logic        closed;

      phase_in      = phase_ff;
      stack_in      = stack_ff;
      nest_in       = nest_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      wide_in       = wide_ff;
      held_in       = held_ff;
      found_in      = found_ff;
      found_time_in = found_time_ff;
      error_in      = error_ff;
      header        = {shift_ff[55:0], req_chan.in_byte};
      box_size      = header[63:32];
      box_type      = header[31:0];
      body          = box_size - MIN_BOX_SIZE;
      skip_left     = (shift_ff != 64'd0) ? shift_ff - 64'd1 : shift_ff;
      stop          = 1'b0;
      closed        = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_HEADER, PH_SKIP: begin
               for (int k = 0; k < MAX_DEPTH; k++) begin
                  if ((NEST_W'(k) < nest_ff) && (stack_ff[k] != 32'd0)) begin
                     stack_in[k] = stack_ff[k] - 32'd1;
                  end
               end
               if (phase_ff == PH_HEADER) begin
                  shift_in = header;
                  count_in = count_ff + 4'd1;
                  if (count_ff == 4'd7) begin
                     count_in = 4'd0;
                     shift_in = 64'd0;
                     if (box_size < MIN_BOX_SIZE) begin
                        error_in = 1'b1;
                        phase_in = PH_DONE;
                        stop     = 1'b1;
                     end else if (box_type == FOURCC_TFDT) begin
                        phase_in = PH_VERFLAGS;
                        stop     = 1'b1;
                     end else if (is_container(box_type)) begin
                        if (nest_ff >= NEST_W'(MAX_DEPTH)) begin
                           error_in = 1'b1;
                           phase_in = PH_DONE;
                           stop     = 1'b1;
                        end else if (body != 32'd0) begin
                           stack_in[nest_ff[IDX_W-1:0]] = body;
                           nest_in = nest_ff + 1'b1;
                        end
                     end else if (body != 32'd0) begin
                        shift_in = {32'd0, body};
                        phase_in = PH_SKIP;
                     end
                  end
               end else begin
                  shift_in = skip_left;
                  if (skip_left == 64'd0) begin
                     phase_in = PH_HEADER;
                  end
               end
               if (!stop) begin
                  for (int k = 0; k < MAX_DEPTH; k++) begin
                     if (!closed && (NEST_W'(k) < nest_ff) && (stack_in[k] == 32'd0)) begin
                        closed   = 1'b1;
                        nest_in  = NEST_W'(k);
                        phase_in = PH_HEADER;
                        count_in = 4'd0;
                        shift_in = 64'd0;
                     end
                  end
               end
            end
            PH_VERFLAGS: begin
               if (count_ff == 4'd0) begin
                  wide_in = (req_chan.in_byte == TFDT_VERSION_LONG);
               end
               count_in = count_ff + 4'd1;
               if (count_ff == 4'd3) begin
                  count_in = 4'd0;
                  held_in  = 64'd0;
                  phase_in = PH_TIME;
               end
            end
            PH_TIME: begin
               held_in  = time_shift;
               count_in = count_ff + 4'd1;
               if (time_done) begin
                  found_in      = 1'b1;
                  found_time_in = new_time;
                  count_in      = 4'd0;
                  held_in       = 64'd0;
                  phase_in      = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         case (phase_ff)
            PH_TIME: begin
               if (time_done) begin
                  push             = 1'b1;
                  push_entry.value = new_time;
                  push_entry.count = need;
               end else if (req_chan.segment_last) begin
                  push             = 1'b1;
                  push_entry.value = time_shift;
                  push_entry.count = count_ff + 4'd1;
               end
            end
            default: begin
               push             = 1'b1;
               push_entry.value = {56'd0, req_chan.in_byte};
               push_entry.count = 4'd1;
            end
         endcase
         if (req_chan.segment_last) begin
            push_entry.last      = 1'b1;
            push_entry.found     = found_in;
            push_entry.stamp     = found_in ? found_time_in : 64'd0;
            push_entry.malformed = error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.segment_last)) begin
         phase_ff      <= PH_HEADER;
         nest_ff       <= '0;
         shift_ff      <= '0;
         count_ff      <= '0;
         wide_ff       <= 1'b0;
         held_ff       <= '0;
         found_ff      <= 1'b0;
         found_time_ff <= '0;
         error_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         nest_ff       <= nest_in;
         shift_ff      <= shift_in;
         count_ff      <= count_in;
         wide_ff       <= wide_in;
         held_ff       <= held_in;
         found_ff      <= found_in;
         found_time_ff <= found_time_in;
         error_ff      <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
   end

endmodule

/* rtl/core/mdtr_back.sv */
// ---------------------------------------------------------------------------
// mdtr_back: byte emitter
// Takes byte groups from the queue and sends them one byte per transfer.
// ---------------------------------------------------------------------------
module mdtr_back
   import mdtr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  mdtr_entry_type head_entry,
   output logic           pop,
   mdtr_rsp_if.source     rsp_chan
);

   logic [63:0] data_ff, data_in;
   logic [3:0]  left_ff, left_in;
   logic        last_ff, last_in;
   logic        found_ff, found_in;
   logic [63:0] stamp_ff, stamp_in;
   logic        malformed_ff, malformed_in;

   logic        take;
   logic        final_byte;
   logic [6:0]  align;

   assign take       = rsp_chan.valid && rsp_chan.ready;
   assign final_byte = last_ff && (left_ff == 4'd1);
   assign pop        = head_valid && ((left_ff == 4'd0) || ((left_ff == 4'd1) && take));
   assign align      = {4'd8 - head_entry.count, 3'd0};

   assign rsp_chan.valid           = (left_ff != 4'd0);
   assign rsp_chan.out_byte        = data_ff[63:56];
   assign rsp_chan.segment_end     = final_byte;
   assign rsp_chan.time_found      = final_byte && found_ff;
   assign rsp_chan.new_decode_time = final_byte ? stamp_ff : 64'd0;
   assign rsp_chan.malformed       = final_byte && malformed_ff;

   always_comb begin
      data_in      = data_ff;
      left_in      = left_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      stamp_in     = stamp_ff;
      malformed_in = malformed_ff;
      if (pop) begin
         data_in      = head_entry.value << align;
         left_in      = head_entry.count;
         last_in      = head_entry.last;
         found_in     = head_entry.found;
         stamp_in     = head_entry.stamp;
         malformed_in = head_entry.malformed;
      end else if (take) begin
         data_in = {data_ff[55:0], 8'd0};
         left_in = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      last_ff      <= last_in;
      found_ff     <= found_in;
      stamp_ff     <= stamp_in;
      malformed_ff <= malformed_in;
   end

endmodule

/* rtl/core/mp4_decode_time_restamper.sv */
// ---------------------------------------------------------------------------
// mp4_decode_time_restamper: tfdt base media decode time rewriter
// Parses an MP4 segment byte stream and adds a signed delta to the first
// tfdt decode time, passing all other bytes through unchanged.
//
//   Channel   Ports         Direction  Payload
//   request   req_chan      in         in_byte, segment_last
//   response  rsp_chan      out        out_byte, segment_end, time_found,
//                                      new_decode_time, malformed
//   config    psel...       in/out     restamp_delta at byte address 0
//
// One segment byte is accepted per cycle while the queue is not full.
// The time field bytes are held in the parser and leave as one group of four
// or eight bytes, which the emitter sends one byte per transfer.
// An accepted byte passes the queue entry and then the emitter register, the
// two stages, before it is offered on the result channel.
// A sixteen-entry queue absorbs the backlog that a time field group leaves, so
// the input stalls only when the output stalls long enough to fill the queue.
// Reset is synchronous.
// ---------------------------------------------------------------------------
module mp4_decode_time_restamper
   import mdtr_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 8
)(
   input  logic                  clock,
   input  logic                  reset,
   mdtr_req_if.sink              req_chan,
   mdtr_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   logic [63:0]    delta_ff, delta_in;
   logic           queue_full;
   logic           push;
   mdtr_entry_type push_entry;
   logic           pop;
   logic           head_valid;
   mdtr_entry_type head_entry;

   assign pready = 1'b1;
   assign prdata = (paddr[3] == REG_RESTAMP_DELTA) ? delta_ff : 64'd0;

   always_comb begin
      delta_in = delta_ff;
      if (psel && penable && pwrite && (paddr[3] == REG_RESTAMP_DELTA)) begin
         delta_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
      end else begin
         delta_ff <= delta_in;
      end
   end

   mdtr_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .restamp_delta (delta_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   mdtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mdtr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
